>>> rtl/core/iwm_pkg.sv
// Shared constants for the isomorphic window matcher.
package iwm_pkg;

  // Default window length in bytes; the pattern registers hold sixteen characters.
  localparam int unsigned MaxPatternDef = 16;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned LEN_CFG_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS_HIGH = 2'd2;

endpackage

>>> rtl/core/isomorphic_window_matcher_core.sv
// Top level of the isomorphic window matcher: window, pairwise compares and match counter.
//
// Usage: text bytes enter on the slave stream, one byte per transfer in
// s_axis_tdata[7:0], with s_axis_tlast marking the final byte of a text.
// Every input transfer yields exactly one output transfer on the master
// stream: bit 0 of m_axis_tdata says whether the window of the last
// pattern_length bytes ending at this byte has the same equality pattern
// as the configured pattern, bits 32:1 carry the saturating match count of
// the current text, and m_axis_tlast repeats the input's last flag. After
// a last byte the window, fill count and match count start over.
// On the way from an input transfer to its output transfer, one register
// stage holds the shifted window and one holds the result. Throughput is
// one byte per cycle while the receiver keeps up, set by the combinational
// parallel compare of all byte pairs in the window. When the receiver
// stalls, the result register and then the window stage fill, and
// s_axis_tready drops after two held items. Reset clears the window, counts
// and both valid flags, and loads pattern_length with 1 and the pattern
// characters with zero. The configuration port must be written only while
// no transfer is in flight; the block itself does not enforce this.
module isomorphic_window_matcher_core #(
  parameter int unsigned MAX_PATTERN = iwm_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream. tdata: text_char [7:0]. tlast: last_char.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [iwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Result stream. tdata: window_match [0], match_count [32:1], zero [39:33].
  // tlast: text_done.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [iwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [iwm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [iwm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import iwm_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_PATTERN);
  localparam logic [COUNT_W-1:0] CountMax = {COUNT_W{1'b1}};

  // Configuration registers.
  logic [LEN_CFG_W-1:0]  pattern_length_q;
  logic [CFG_DATA_W-1:0] pattern_chars_low_q;
  logic [CFG_DATA_W-1:0] pattern_chars_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q     <= LEN_CFG_W'(1);
      pattern_chars_low_q  <= '0;
      pattern_chars_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data_i[LEN_CFG_W-1:0];
        REG_PATTERN_CHARS_LOW:  pattern_chars_low_q  <= cfg_data_i;
        REG_PATTERN_CHARS_HIGH: pattern_chars_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective length: zero counts as one, oversize is clipped to the window.
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] eff_len_m1;

  always_comb begin
    if (pattern_length_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length_q > LEN_CFG_W'(MAX_PATTERN)) begin
      eff_len = LenMax;
    end else begin
      eff_len = pattern_length_q[LEN_W-1:0];
    end
    eff_len_m1 = eff_len - LEN_W'(1);
  end

  // Handshake control.
  logic s_fire;
  logic out_free;
  logic adv2;
  logic v1_q;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !v1_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign adv2          = v1_q && out_free;

  // Stage 1: text history (entry 0 newest) and a snapshot of the shifted window.
  logic [CHAR_W-1:0] window_q [MAX_PATTERN];
  logic [CHAR_W-1:0] win1_q   [MAX_PATTERN];
  logic [CHAR_W-1:0] shifted  [MAX_PATTERN];
  logic [LEN_W-1:0]  held_q;
  logic [LEN_W-1:0]  held_inc;
  logic [LEN_W-1:0]  held1_q;
  logic              last1_q;

  always_comb begin
    shifted[0] = s_axis_tdata[CHAR_W-1:0];
    for (int k = 1; k < MAX_PATTERN; k++) begin
      shifted[k] = window_q[k-1];
    end
    held_inc = (held_q == LenMax) ? held_q : held_q + LEN_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      held_q <= '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window_q[k] <= '0;
      end
    end else if (s_fire) begin
      v1_q <= 1'b1;
      if (s_axis_tlast) begin
        held_q <= '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          window_q[k] <= '0;
        end
      end else begin
        held_q   <= held_inc;
        window_q <= shifted;
      end
    end else if (out_free) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      win1_q  <= shifted;
      held1_q <= held_inc;
      last1_q <= s_axis_tlast;
    end
  end

  // Stage 2: pairwise equality of window bytes and pattern bytes, one
  // candidate result per possible length, then selection by the length.
  logic [CHAR_W-1:0]      pat_char [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] te_m     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] pe_m     [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] match_len;
  logic                   match;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i < 8) begin
        pat_char[i] = pattern_chars_low_q[CHAR_W*(i%8) +: CHAR_W];
      end else begin
        pat_char[i] = pattern_chars_high_q[CHAR_W*(i%8) +: CHAR_W];
      end
    end
    for (int a = 0; a < MAX_PATTERN; a++) begin
      for (int b = 0; b < MAX_PATTERN; b++) begin
        te_m[a][b] = (win1_q[a] == win1_q[b]);
        pe_m[a][b] = (pat_char[a] == pat_char[b]);
      end
    end
    // For length L, pattern position i sits at window entry L-1-i.
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      match_len[l-1] = 1'b1;
      for (int i = 0; i < l; i++) begin
        for (int j = i + 1; j < l; j++) begin
          if (te_m[l-1-i][l-1-j] != pe_m[i][j]) begin
            match_len[l-1] = 1'b0;
          end
        end
      end
    end
    match = (held1_q >= eff_len) && match_len[eff_len_m1[IDX_W-1:0]];
  end

  // Match counter and result register.
  logic [COUNT_W-1:0] cnt_q;
  logic [COUNT_W-1:0] cnt_new;

  assign cnt_new = (match && (cnt_q != CountMax)) ? cnt_q + COUNT_W'(1) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else if (adv2) begin
      cnt_q         <= last1_q ? '0 : cnt_new;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      m_axis_tdata <= {(OUT_TDATA_W-COUNT_W-1)'(0), cnt_new, match};
      m_axis_tlast <= last1_q;
    end
  end

  // Checks on the block's own control.
  a_ready_low_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && m_axis_tvalid))
    else $error("input stalled while a stage was free");

  a_last_clears_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast) |=> (held_q == '0))
    else $error("fill count not cleared after last byte");

  a_match_needs_full_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && match) |-> (held1_q >= eff_len))
    else $error("match reported on a partial window");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv2 && !last1_q) |=> (cnt_q >= $past(cnt_q)))
    else $error("match count decreased within a text");

  a_result_follows_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv2 |=> m_axis_tvalid)
    else $error("result lost on its way to the output register");

endmodule

>>> tb/iwm_match_checker.sv
// Result checker for the isomorphic window matcher: tracks the window, compares results.
`timescale 1ns / 1ps
module iwm_match_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [iwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // text_char [7:0]
  input  logic                            s_axis_tlast,   // last_char
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [iwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // window_match [0], match_count [32:1]
  input  logic                            m_axis_tlast,   // text_done
  input  logic                            cfg_we_i,
  input  logic [iwm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [iwm_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output int                              pending_o,
  output int                              mismatches_o
);
  import iwm_pkg::*;

  typedef struct packed {
    logic               matched;
    logic [COUNT_W-1:0] count;
    logic               done;
  } match_result_t;

  match_result_t        expected_results[$];
  logic [CHAR_W-1:0]    text_window[MaxPatternDef];
  int unsigned          window_fill;
  logic [COUNT_W-1:0]   text_matches;
  logic [LEN_CFG_W-1:0] length_reg;
  logic [CFG_DATA_W-1:0] chars_low_reg;
  logic [CFG_DATA_W-1:0] chars_high_reg;
  int                   fail_total;

  function automatic int unsigned effective_length();
    int unsigned l;
    l = length_reg;
    if (l < 1) l = 1;
    if (l > MaxPatternDef) l = MaxPatternDef;
    return l;
  endfunction

  function automatic logic [CHAR_W-1:0] pattern_char(int unsigned i);
    if (i < 8) return chars_low_reg[i*8 +: 8];
    return chars_high_reg[(i-8)*8 +: 8];
  endfunction

  // Position i counts from the oldest byte of the window; the newest byte sits in entry 0.
  function automatic logic same_shape(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      for (int unsigned j = 0; j < len; j++) begin
        if ((text_window[len-1-i] == text_window[len-1-j]) !=
            (pattern_char(i) == pattern_char(j))) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void clear_text();
    foreach (text_window[k]) text_window[k] = '0;
    window_fill  = 0;
    text_matches = '0;
  endfunction

  function automatic match_result_t step_text(logic [CHAR_W-1:0] c, logic last);
    match_result_t r;
    int unsigned   len;
    len = effective_length();
    for (int k = MaxPatternDef - 1; k > 0; k--) text_window[k] = text_window[k-1];
    text_window[0] = c;
    if (window_fill < MaxPatternDef) window_fill++;
    r.matched = (window_fill >= len) && same_shape(len);
    if (r.matched && text_matches != '1) text_matches++;
    r.count = text_matches;
    r.done  = last;
    if (last) clear_text();
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_result_t want;
    if (!rst_ni) begin
      clear_text();
      length_reg     = LEN_CFG_W'(1);
      chars_low_reg  = '0;
      chars_high_reg = '0;
      expected_results.delete();
      fail_total     = 0;
    end else begin
      // A result never leaves in the same cycle that its byte is taken, so retire before pushing.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("unexpected result: match=%0b count=%0d done=%0b",
                     m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tlast);
        end else begin
          want = expected_results.pop_front();
          if (want.matched !== m_axis_tdata[0] || want.count !== m_axis_tdata[32:1] ||
              want.done !== m_axis_tlast) begin
            fail_total++;
            if (fail_total <= 10)
              $display({"result mismatch: expected match=%0b count=%0d done=%0b, ",
                        "got match=%0b count=%0d done=%0b"},
                       want.matched, want.count, want.done,
                       m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tlast);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PATTERN_LENGTH:     length_reg     = cfg_data_i[LEN_CFG_W-1:0];
          REG_PATTERN_CHARS_LOW:  chars_low_reg  = cfg_data_i;
          REG_PATTERN_CHARS_HIGH: chars_high_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(step_text(s_axis_tdata[CHAR_W-1:0], s_axis_tlast));
    end
    pending_o    <= expected_results.size();
    mismatches_o <= fail_total;
  end

endmodule

>>> tb/tb.sv
// Testbench top for the isomorphic window matcher: stimulus, stall watchdog and verdict.
`timescale 1ns / 1ps
module tb;
  import iwm_pkg::*;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung. The longest
  // legitimate quiet stretch is the long receiver hold plus a few config writes.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // text_char [7:0]
  logic                   s_axis_tlast = 1'b0; // last_char
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // window_match [0], match_count [32:1]
  logic                   m_axis_tlast;        // text_done
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int          pending;
  int          mismatches;
  int unsigned quiet_cycles = 0;
  // Idling controls: send_gaps for the sender, recv_gaps and hold_request for the receiver.
  logic        send_gaps = 1'b0;
  logic        recv_gaps = 1'b0;
  logic        hold_request = 1'b0;

  // Local copy of the pattern, used only to build text: planted matches and filler bytes.
  logic [7:0]  pattern_bytes[16];
  int unsigned active_length = 1;

  isomorphic_window_matcher_core uut (.*);

  iwm_match_checker result_check (
    .pending_o    (pending),
    .mismatches_o (mismatches),
    .*
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: any transfer on either stream restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. A long hold is counted here, in its own process, so the sender
  // keeps offering bytes and the block has to back up and drop s_axis_tready.
  // Otherwise it stalls in short random bursts while recv_gaps is set.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // The write enable is lowered after the write is taken and the task returns only at a
  // later edge, so back-to-back writes never assign it twice within one time step.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits are random so the block must ignore them.
  task automatic set_length(logic [LEN_CFG_W-1:0] v);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[LEN_CFG_W-1:0] = v;
    write_reg(REG_PATTERN_LENGTH, data);
    active_length = (v == 0) ? 1 : (v > 16) ? 16 : v;
  endtask

  task automatic set_pattern(logic [LEN_CFG_W-1:0] len_value, logic [63:0] low,
                             logic [63:0] high);
    write_reg(REG_PATTERN_CHARS_LOW, low);
    write_reg(REG_PATTERN_CHARS_HIGH, high);
    set_length(len_value);
    for (int i = 0; i < 8; i++) begin
      pattern_bytes[i]   = low[i*8 +: 8];
      pattern_bytes[i+8] = high[i*8 +: 8];
    end
  endtask

  // Offers one byte and returns at the edge where it is taken. Valid stays high
  // into the next call unless that call opens a gap.
  task automatic send_byte(logic [7:0] c, logic last);
    if (send_gaps && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering and waits until every result has come back. The first edge
  // lets the checker count a byte that was taken at the current edge.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Sends a copy of the pattern's equality shape under a fresh, one-to-one
  // relabeling of its characters, so the window ending on its last byte matches.
  task automatic send_planted(logic last);
    logic [7:0]  label[16];
    logic [7:0]  candidate;
    logic        clash;
    int unsigned q;
    for (int unsigned p = 0; p < active_length; p++) begin
      q = 0;
      while (pattern_bytes[q] != pattern_bytes[p]) q++;
      if (q == p) begin
        do begin
          candidate = 8'($urandom);
          clash = 1'b0;
          for (int unsigned r = 0; r < p; r++) if (label[r] == candidate) clash = 1'b1;
        end while (clash);
        label[p] = candidate;
      end else begin
        label[p] = label[q];
      end
    end
    for (int unsigned p = 0; p < active_length; p++)
      send_byte(label[p], last && (p == active_length - 1));
  endtask

  // Filler bytes are mostly drawn from the pattern itself so that windows
  // often come close to matching; a quarter are arbitrary bytes.
  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return pattern_bytes[$urandom_range(0, active_length - 1)];
  endfunction

  task automatic send_text(int unsigned budget, logic close);
    int unsigned n;
    n = 0;
    while (n < budget) begin
      if ($urandom_range(0, 9) < 6 && n + active_length <= budget) begin
        send_planted(close && (n + active_length == budget));
        n += active_length;
      end else begin
        send_byte(filler_byte(), close && (n + 1 == budget));
        n++;
      end
    end
  endtask

  // One configuration phase. An alphabet of zero keeps the pattern characters
  // and rewrites only the length; when the previous phase left a text open
  // this changes the length in the middle of a text.
  task automatic run_phase(logic [LEN_CFG_W-1:0] len_value, int unsigned alphabet,
                           int unsigned items, logic close_final);
    logic [7:0]  symbols[16];
    logic [63:0] low;
    logic [63:0] high;
    int unsigned sent;
    int unsigned text_len;
    drain();
    if (alphabet == 0) begin
      set_length(len_value);
    end else begin
      for (int unsigned s = 0; s < alphabet; s++) symbols[s] = 8'($urandom);
      for (int i = 0; i < 8; i++) begin
        low[i*8 +: 8]  = symbols[$urandom_range(0, alphabet - 1)];
        high[i*8 +: 8] = symbols[$urandom_range(0, alphabet - 1)];
      end
      set_pattern(len_value, low, high);
    end
    sent = 0;
    while (sent < items) begin
      text_len = $urandom_range(1, 48);
      if (sent + text_len > items) text_len = items - sent;
      send_text(text_len, close_final || (sent + text_len < items));
      sent += text_len;
    end
  endtask

  initial begin
    foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset settings: length one with an
    // all-zero pattern, where every single byte is a match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();
    // Pattern "aba": the window is not full for the first two bytes, then
    // matches, matches, and fails twice.
    set_pattern(LEN_CFG_W'(3), 64'h0000_0000_0061_6261, 64'h0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Length shortened in the middle of a text: the held bytes are matched
    // against "ab" at once.
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    drain();
    set_length(LEN_CFG_W'(2));
    send_byte(8'h56, 1'b1);

    // Random part with idling on both sides.
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    run_phase(LEN_CFG_W'(16), 3, 220, 1'b1);
    run_phase(LEN_CFG_W'(0), 2, 150, 1'b1);
    run_phase(LEN_CFG_W'(31), 4, 200, 1'b0);
    run_phase(LEN_CFG_W'(5), 0, 150, 1'b1);
    drain();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    run_phase(LEN_CFG_W'(17), 16, 150, 1'b1);

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender streams without gaps, so the block fills and stalls its input.
    drain();
    send_gaps    = 1'b0;
    hold_request = 1'b1;
    run_phase(LEN_CFG_W'(4), 2, 200, 1'b1);
    send_gaps = 1'b1;

    repeat (5) begin
      run_phase(LEN_CFG_W'($urandom_range(0, 31)), $urandom_range(1, 5), 150,
                1'($urandom_range(0, 1)));
    end

    // Closing stretch with no idling on either side.
    drain();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    run_phase(LEN_CFG_W'($urandom_range(1, 16)), $urandom_range(1, 4), 150, 1'b1);

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
